// ===== rtl/core/keyframe_color_ramp_sampler_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the keyframe color ramp sampler
// Shared property forms used by the RTL that carries assertions.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_COLOR_RAMP_SAMPLER_TOP_DEFINES_SVH
`define KEYFRAME_COLOR_RAMP_SAMPLER_TOP_DEFINES_SVH

// Overlapping implication, disabled while reset is asserted.
`define KCR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, active during reset as well.
`define KCR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/kcr_pkg.sv =====
// ----------------------------------------------------------------------------
// kcr_pkg
// Types and constants shared by the keyframe color ramp sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package kcr_pkg;

    localparam int KF_W   = 42;
    localparam int PROG_W = 10;
    localparam int DUR_W  = 32;
    localparam int KC_W   = 3;

    localparam int DEF_MAX_KEYFRAMES = 6;
    localparam int DEF_GAMMA_POWER   = 2;

    localparam logic [PROG_W-1:0] PROG_FULL = 10'd1000;

    localparam logic [DUR_W-1:0] DUR_RESET    = 32'd1800000;
    localparam logic [KC_W-1:0]  KCOUNT_RESET = 3'd2;
    localparam logic [KF_W-1:0]  KF1_RESET    = 42'd4299262263295;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 42;
    localparam logic [CFG_IDX_W-1:0] CFG_DURATION = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KCOUNT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KF_BASE  = 3'd2;

    // Pipeline depths of the progress and interpolation sections.
    localparam int PROG_LAT = 12;
    localparam int LERP_LAT = 11;

    typedef logic [0:3][7:0] t_rgbw;

    typedef struct packed {
        logic              valid;
        logic [PROG_W-1:0] prog;
    } t_ctl;

endpackage

`default_nettype wire

// ===== rtl/core/kcr_prog_div.sv =====
// ----------------------------------------------------------------------------
// kcr_prog_div
// Progress in permille: a multiply stage, ten restoring divide stages, saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module kcr_prog_div import kcr_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [DUR_W-1:0] i_elapsed_ms,
    input  wire logic [DUR_W-1:0] i_duration_ms,
    output t_ctl                  o_ctl
);

    localparam int QB = PROG_W;
    localparam int NW = DUR_W + PROG_W;

    logic [NW-1:0] r_rem [QB];
    logic [QB-1:0] r_q   [QB+1];
    logic          r_v   [QB+1];
    logic          r_sat [QB+1];
    t_ctl          r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_rem[0] <= {{PROG_W{1'b0}}, i_elapsed_ms} * NW'(1000);
        r_q[0]   <= '0;
        r_sat[0] <= (i_duration_ms == '0) || (i_elapsed_ms >= i_duration_ms);
    end

    for (genvar j = 0; j < QB; j++) begin : g_div
        localparam int K = QB - 1 - j;
        logic [NW-1:0] w_d;
        logic          w_ge;
        assign w_d  = {{PROG_W{1'b0}}, i_duration_ms} << K;
        assign w_ge = r_rem[j] >= w_d;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j+1] <= 1'b0;
            end else begin
                r_v[j+1] <= r_v[j];
            end
            r_sat[j+1] <= r_sat[j];
            r_q[j+1]   <= r_q[j] | (w_ge ? (QB'(1) << K) : '0);
        end

        if (j < QB - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                r_rem[j+1] <= w_ge ? (r_rem[j] - w_d) : r_rem[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else begin
            r_out.valid <= r_v[QB];
        end
        r_out.prog <= r_sat[QB] ? PROG_FULL : r_q[QB];
    end

    assign o_ctl = r_out;

endmodule

`default_nettype wire

// ===== rtl/core/kcr_lerp.sv =====
// ----------------------------------------------------------------------------
// kcr_lerp
// Segment search and rounded linear interpolation of the four channels.
// ----------------------------------------------------------------------------
`default_nettype none

module kcr_lerp import kcr_pkg::*; #(
    parameter int MAX_KEYFRAMES = DEF_MAX_KEYFRAMES
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  t_ctl                 i_ctl,
    input  wire logic [KF_W-1:0] i_kf [MAX_KEYFRAMES],
    input  wire logic [KC_W-1:0] i_kcount,
    output t_ctl                 o_ctl,
    output t_rgbw                o_rgbw
);

    localparam int QB = 8;
    localparam int MW = 19;

    // Search stage.
    logic [KC_W-1:0]   w_cnt;
    t_rgbw             n_a;
    t_rgbw             n_b;
    logic [PROG_W-1:0] n_num;
    logic [PROG_W-1:0] n_den;

    always_comb begin
        if (i_kcount == '0) begin
            w_cnt = KC_W'(1);
        end else if (i_kcount > KC_W'(MAX_KEYFRAMES)) begin
            w_cnt = KC_W'(MAX_KEYFRAMES);
        end else begin
            w_cnt = i_kcount;
        end
    end

    always_comb begin
        n_a   = t_rgbw'(i_kf[0][31:0]);
        n_b   = n_a;
        n_num = '0;
        n_den = PROG_W'(1);
        if (i_ctl.prog > i_kf[0][41:32]) begin
            for (int i = 0; i < MAX_KEYFRAMES; i++) begin
                if (KC_W'(i) == w_cnt - KC_W'(1)) begin
                    n_a = t_rgbw'(i_kf[i][31:0]);
                    n_b = n_a;
                end
            end
            // Descending order so the lowest matching keyframe wins.
            for (int i = MAX_KEYFRAMES - 1; i >= 1; i--) begin
                if (KC_W'(i) < w_cnt && i_ctl.prog <= i_kf[i][41:32]) begin
                    n_a   = t_rgbw'(i_kf[i-1][31:0]);
                    n_b   = t_rgbw'(i_kf[i][31:0]);
                    n_num = i_ctl.prog - i_kf[i-1][41:32];
                    n_den = i_kf[i][41:32] - i_kf[i-1][41:32];
                end
            end
        end
    end

    t_ctl               r1_ctl;
    t_rgbw              r1_a;
    logic signed [8:0]  r1_delta [4];
    logic [PROG_W-1:0]  r1_num;
    logic [PROG_W-1:0]  r1_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl.valid <= 1'b0;
        end else begin
            r1_ctl.valid <= i_ctl.valid;
        end
        r1_ctl.prog <= i_ctl.prog;
        r1_a        <= n_a;
        r1_num      <= n_num;
        r1_den      <= n_den;
        for (int c = 0; c < 4; c++) begin
            r1_delta[c] <= $signed({1'b0, n_b[c]}) - $signed({1'b0, n_a[c]});
        end
    end

    // Product stage and divide stages; index 0 holds the rounded product.
    t_ctl              r_ctl  [QB+1];
    t_rgbw             r_a    [QB+1];
    logic [PROG_W-1:0] r_den  [QB+1];
    logic              r_sign [QB+1][4];
    logic [MW-1:0]     r_rem  [QB][4];
    logic [QB-1:0]     r_q    [QB+1][4];

    logic signed [20:0] w_sum [4];

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            w_sum[c] = r1_delta[c] * $signed({1'b0, r1_num})
                     + $signed({11'b0, r1_den[PROG_W-1:1]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl[0].valid <= 1'b0;
        end else begin
            r_ctl[0].valid <= r1_ctl.valid;
        end
        r_ctl[0].prog <= r1_ctl.prog;
        r_a[0]        <= r1_a;
        r_den[0]      <= r1_den;
        for (int c = 0; c < 4; c++) begin
            r_sign[0][c] <= w_sum[c][20];
            r_rem[0][c]  <= MW'(w_sum[c][20] ? -w_sum[c] : w_sum[c]);
            r_q[0][c]    <= '0;
        end
    end

    for (genvar j = 0; j < QB; j++) begin : g_div
        localparam int K = QB - 1 - j;
        logic [MW-1:0] w_d;
        logic          w_ge [4];
        assign w_d = {{(MW-PROG_W){1'b0}}, r_den[j]} << K;
        for (genvar c = 0; c < 4; c++) begin : g_ge
            assign w_ge[c] = r_rem[j][c] >= w_d;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[j+1].valid <= 1'b0;
            end else begin
                r_ctl[j+1].valid <= r_ctl[j].valid;
            end
            r_ctl[j+1].prog <= r_ctl[j].prog;
            r_a[j+1]        <= r_a[j];
            r_den[j+1]      <= r_den[j];
            for (int c = 0; c < 4; c++) begin
                r_sign[j+1][c] <= r_sign[j][c];
                r_q[j+1][c]    <= r_q[j][c] | (w_ge[c] ? (QB'(1) << K) : '0);
            end
        end

        if (j < QB - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                for (int c = 0; c < 4; c++) begin
                    r_rem[j+1][c] <= w_ge[c] ? (r_rem[j][c] - w_d) : r_rem[j][c];
                end
            end
        end
    end

    // Add the signed step to the left color and clamp.
    t_ctl              r_out_ctl;
    t_rgbw             r_out;
    logic signed [9:0] w_v [4];
    t_rgbw             n_out;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            w_v[c] = r_sign[QB][c]
                   ? $signed({2'b0, r_a[QB][c]}) - $signed({2'b0, r_q[QB][c]})
                   : $signed({2'b0, r_a[QB][c]}) + $signed({2'b0, r_q[QB][c]});
            if (w_v[c] < 0) begin
                n_out[c] = 8'd0;
            end else if (w_v[c] > 10'sd255) begin
                n_out[c] = 8'd255;
            end else begin
                n_out[c] = w_v[c][7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_ctl.valid <= 1'b0;
        end else begin
            r_out_ctl.valid <= r_ctl[QB].valid;
        end
        r_out_ctl.prog <= r_ctl[QB].prog;
        r_out          <= n_out;
    end

    assign o_ctl  = r_out_ctl;
    assign o_rgbw = r_out;

endmodule

`default_nettype wire

// ===== rtl/core/kcr_gamma.sv =====
// ----------------------------------------------------------------------------
// kcr_gamma
// Power shaping of each channel, one multiply and divide by 255 per stage after the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module kcr_gamma import kcr_pkg::*; #(
    parameter int GAMMA_POWER = DEF_GAMMA_POWER
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_ctl      i_ctl,
    input  t_rgbw     i_rgbw,
    output t_ctl      o_ctl,
    output t_rgbw     o_rgbw
);

    // Exact division by 255 for products up to 255 * 255.
    function automatic logic [7:0] mul_div255(input logic [7:0] a, input logic [7:0] b);
        logic [15:0] p;
        logic [16:0] t;
        p = a * b;
        t = 17'(p) + 17'd1 + 17'(p[15:8]);
        return t[15:8];
    endfunction

    t_ctl  r_ctl [GAMMA_POWER];
    t_rgbw r_o   [GAMMA_POWER];
    t_rgbw r_v   [GAMMA_POWER];

    for (genvar g = 0; g < GAMMA_POWER; g++) begin : g_stage
        if (g == 0) begin : g_in
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_ctl[0].valid <= 1'b0;
                end else begin
                    r_ctl[0].valid <= i_ctl.valid;
                end
                r_ctl[0].prog <= i_ctl.prog;
                r_o[0]        <= i_rgbw;
                r_v[0]        <= i_rgbw;
            end
        end else begin : g_mul
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_ctl[g].valid <= 1'b0;
                end else begin
                    r_ctl[g].valid <= r_ctl[g-1].valid;
                end
                r_ctl[g].prog <= r_ctl[g-1].prog;
                r_v[g]        <= r_v[g-1];
                for (int c = 0; c < 4; c++) begin
                    r_o[g][c] <= mul_div255(r_o[g-1][c], r_v[g-1][c]);
                end
            end
        end
    end

    t_ctl  r_out_ctl;
    t_rgbw r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_ctl.valid <= 1'b0;
        end else begin
            r_out_ctl.valid <= r_ctl[GAMMA_POWER-1].valid;
        end
        r_out_ctl.prog <= r_ctl[GAMMA_POWER-1].prog;
        for (int c = 0; c < 4; c++) begin
            // A lit channel never shapes to dark.
            if (r_v[GAMMA_POWER-1][c] == 8'd0) begin
                r_out[c] <= 8'd0;
            end else if (r_o[GAMMA_POWER-1][c] == 8'd0) begin
                r_out[c] <= 8'd1;
            end else begin
                r_out[c] <= r_o[GAMMA_POWER-1][c];
            end
        end
    end

    assign o_ctl  = r_out_ctl;
    assign o_rgbw = r_out;

endmodule

`default_nettype wire

// ===== rtl/core/keyframe_color_ramp_sampler_top.sv =====
// ----------------------------------------------------------------------------
// keyframe_color_ramp_sampler_top
// Samples a keyframed RGBW ramp at an elapsed time and shapes the levels.
// ----------------------------------------------------------------------------
// A sample request is transferred when start is high at a rising clock edge;
// busy is always low, so a new elapsed time may be given in every cycle.
// Each request yields exactly one result: o_strobe is high for one cycle with
// the shaped red, green, blue and white levels, the progress in permille and
// the complete flag. Results come out in request order, one per cycle at most.
// In order, one multiply stage and ten restoring divide stages form the
// progress, eleven stages search the segment and divide the rounded
// interpolation step, and one stage per power term shapes the channels.
// The result receiver cannot stall; results are simply presented.
// The configuration port writes one register per cycle: index 0 is the
// duration, 1 the keyframe count, 2 and up the keyframes. Indexes beyond the
// stored keyframes are dropped. Registers are only to be written while no
// request is in flight. Synchronous reset clears the pipeline valid bits and
// loads the default duration, a count of two and a black to white ramp.
// ----------------------------------------------------------------------------
`default_nettype none

`include "keyframe_color_ramp_sampler_top_defines.svh"

module keyframe_color_ramp_sampler_top import kcr_pkg::*; #(
    parameter int MAX_KEYFRAMES = DEF_MAX_KEYFRAMES,
    parameter int GAMMA_POWER   = DEF_GAMMA_POWER
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [DUR_W-1:0]     i_elapsed_ms,
    output logic                      o_strobe,
    output logic [7:0]                o_red,
    output logic [7:0]                o_green,
    output logic [7:0]                o_blue,
    output logic [7:0]                o_white,
    output logic [PROG_W-1:0]         o_progress_permille,
    output logic                      o_complete,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int LAT = PROG_LAT + LERP_LAT + GAMMA_POWER + 1;

    // The pipeline never backs up, so requests are always taken.
    assign busy = 1'b0;

    logic w_accept;
    assign w_accept = start && !busy;

    // Configuration registers.
    logic [DUR_W-1:0] r_duration;
    logic [KC_W-1:0]  r_kcount;
    logic [KF_W-1:0]  r_kf [MAX_KEYFRAMES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duration <= DUR_RESET;
            r_kcount   <= KCOUNT_RESET;
            for (int i = 0; i < MAX_KEYFRAMES; i++) begin
                r_kf[i] <= (i == 1) ? KF1_RESET : '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DURATION: r_duration <= i_cfg_data[DUR_W-1:0];
                CFG_KCOUNT:   r_kcount   <= i_cfg_data[KC_W-1:0];
                default: begin
                    for (int i = 0; i < MAX_KEYFRAMES; i++) begin
                        if ({1'b0, i_cfg_idx} == (CFG_IDX_W+1)'(CFG_KF_BASE) + (CFG_IDX_W+1)'(i))
                        begin
                            r_kf[i] <= i_cfg_data[KF_W-1:0];
                        end
                    end
                end
            endcase
        end
    end

    // Progress, then interpolation, then shaping.
    t_ctl  w_prog_ctl;
    t_ctl  w_lerp_ctl;
    t_ctl  w_out_ctl;
    t_rgbw w_lerp_rgbw;
    t_rgbw w_out_rgbw;

    kcr_prog_div u_prog (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_accept),
        .i_elapsed_ms  (i_elapsed_ms),
        .i_duration_ms (r_duration),
        .o_ctl         (w_prog_ctl)
    );

    kcr_lerp #(
        .MAX_KEYFRAMES (MAX_KEYFRAMES)
    ) u_lerp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_prog_ctl),
        .i_kf     (r_kf),
        .i_kcount (r_kcount),
        .o_ctl    (w_lerp_ctl),
        .o_rgbw   (w_lerp_rgbw)
    );

    kcr_gamma #(
        .GAMMA_POWER (GAMMA_POWER)
    ) u_gamma (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_lerp_ctl),
        .i_rgbw  (w_lerp_rgbw),
        .o_ctl   (w_out_ctl),
        .o_rgbw  (w_out_rgbw)
    );

    assign o_strobe            = w_out_ctl.valid;
    assign o_red               = w_out_rgbw[0];
    assign o_green             = w_out_rgbw[1];
    assign o_blue              = w_out_rgbw[2];
    assign o_white             = w_out_rgbw[3];
    assign o_progress_permille = w_out_ctl.prog;
    assign o_complete          = (w_out_ctl.prog == PROG_FULL);

    // Every transfer in produces a strobe after the fixed pipeline depth.
    `KCR_ASSERT_IMP(a_latency, w_accept, ##LAT o_strobe, "result missing after latency")
    // Progress never exceeds full scale.
    `KCR_ASSERT_IMP(a_prog_range, o_strobe, o_progress_permille <= PROG_FULL,
                    "progress above 1000")
    // With a zero duration every sample is complete.
    `KCR_ASSERT_IMP(a_zero_dur, w_accept && r_duration == '0, ##LAT o_complete,
                    "zero duration sample not complete")
    // Reset empties the pipeline.
    `KCR_ASSERT_NXT(a_reset_flush, !i_rst_n, !o_strobe, "strobe right after reset")

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe color ramp sampler testbench
// Drives elapsed times through the command port and checks every result
// against a local prediction of progress, segment search, interpolation and
// gamma shaping, under several register settings and random sender gaps.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench import kcr_pkg::*; ();

    localparam int GAMMA   = DEF_GAMMA_POWER;
    localparam int MAX_KF  = DEF_MAX_KEYFRAMES;
    // Pipeline depths from the package and the gamma power, plus a margin.
    localparam int SETTLE  = PROG_LAT + LERP_LAT + GAMMA + 8;
    localparam int LIMIT   = 300000;

    typedef struct packed {
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        logic [7:0]        white;
        logic [PROG_W-1:0] progress;
        logic              complete;
    } t_levels;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [DUR_W-1:0]     i_elapsed_ms = '0;
    logic                 o_strobe;
    logic [7:0]           o_red, o_green, o_blue, o_white;
    logic [PROG_W-1:0]    o_progress_permille;
    logic                 o_complete;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;

    // Local copy of the registers, tracking every write to the block.
    logic [DUR_W-1:0] ramp_duration = DUR_RESET;
    logic [KC_W-1:0]  kf_count      = KCOUNT_RESET;
    logic [KF_W-1:0]  kf_table [MAX_KF];

    t_levels pending_levels [$];
    bit      failed = 1'b0;
    int      cycle_count = 0;
    int      burst_left = 0;

    keyframe_color_ramp_sampler_top dut (
        .i_clk, .i_rst_n, .start, .busy, .i_elapsed_ms, .o_strobe,
        .o_red, .o_green, .o_blue, .o_white, .o_progress_permille, .o_complete,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [7:0] shape_level(input logic [7:0] lvl);
        int unsigned acc;
        acc = 32'(lvl);
        if (lvl == 0) return 8'd0;
        for (int k = 1; k < GAMMA; k++) acc = (acc * lvl) / 255;
        return (acc < 1) ? 8'd1 : acc[7:0];
    endfunction

    function automatic logic [7:0] blend_level(input logic [7:0] a, input logic [7:0] b,
                                               input int num, input int den);
        int step;
        int lvl;
        if (den == 0) return a;
        step = int'(b) - int'(a);
        // SystemVerilog integer division truncates toward zero, as required.
        lvl = int'(a) + (step * num + den / 2) / den;
        if (lvl < 0) lvl = 0;
        if (lvl > 255) lvl = 255;
        return lvl[7:0];
    endfunction

    function automatic t_levels ramp_sample(input logic [DUR_W-1:0] elapsed);
        t_levels          res;
        logic [63:0]      prod;
        int               prog, cnt, seg, p0, p1;
        logic [7:0]       lvl [4];
        logic [KF_W-1:0]  lo_kf, hi_kf;
        if (ramp_duration == 0 || elapsed >= ramp_duration) begin
            prog = 1000;
        end else begin
            prod = 64'(elapsed) * 64'd1000;
            prog = int'(prod / 64'(ramp_duration));
        end
        // A count of zero acts as one; anything above the table size is clipped.
        cnt = (kf_count < 1) ? 1 : int'(kf_count);
        if (cnt > MAX_KF) cnt = MAX_KF;
        seg = 0;
        if (prog <= int'(kf_table[0][41:32])) begin
            for (int c = 0; c < 4; c++) lvl[c] = kf_table[0][31-8*c -: 8];
        end else begin
            for (int k = 1; k < cnt; k++) begin
                if (seg == 0 && prog <= int'(kf_table[k][41:32])) seg = k;
            end
            if (seg != 0) begin
                lo_kf = kf_table[seg-1];
                hi_kf = kf_table[seg];
                p0 = int'(lo_kf[41:32]);
                p1 = int'(hi_kf[41:32]);
                for (int c = 0; c < 4; c++)
                    lvl[c] = blend_level(lo_kf[31-8*c -: 8], hi_kf[31-8*c -: 8],
                                         prog - p0, p1 - p0);
            end else begin
                // Past the last keyframe in use the last color holds.
                for (int c = 0; c < 4; c++) lvl[c] = kf_table[cnt-1][31-8*c -: 8];
            end
        end
        res.red      = shape_level(lvl[0]);
        res.green    = shape_level(lvl[1]);
        res.blue     = shape_level(lvl[2]);
        res.white    = shape_level(lvl[3]);
        res.progress = prog[PROG_W-1:0];
        res.complete = (prog >= 1000);
        return res;
    endfunction

    task automatic compare_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            failed = 1'b1;
        end
    endtask

    // Result checking, expectation capture on every transfer, and the watchdog.
    always @(posedge i_clk) begin
        t_levels exp_r;
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("FAIL");
            $finish;
        end
        if (i_rst_n && o_strobe) begin
            if (pending_levels.size() == 0) begin
                $error("result with no outstanding request");
                failed = 1'b1;
            end else begin
                exp_r = pending_levels.pop_front();
                compare_field("red", int'(exp_r.red), int'(o_red));
                compare_field("green", int'(exp_r.green), int'(o_green));
                compare_field("blue", int'(exp_r.blue), int'(o_blue));
                compare_field("white", int'(exp_r.white), int'(o_white));
                compare_field("progress_permille", int'(exp_r.progress),
                              int'(o_progress_permille));
                compare_field("complete", int'(exp_r.complete), int'(o_complete));
            end
        end
        // The request is taken at this edge when start is high and busy is low.
        if (i_rst_n && start && !busy)
            pending_levels.push_back(ramp_sample(i_elapsed_ms));
    end

    // Sends one elapsed time. The sender runs in bursts with random idle gaps.
    task automatic send_sample(input logic [DUR_W-1:0] elapsed);
        bit held;
        i_cfg_we <= 1'b0;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            if ($urandom_range(0, 4) != 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        burst_left--;
        start        <= 1'b1;
        i_elapsed_ms <= elapsed;
        // Busy is checked mid-cycle so the decision never races the edge.
        do begin
            @(negedge i_clk);
            held = busy;
            @(posedge i_clk);
        end while (held);
    endtask

    // Waits until every outstanding result has come back and the pipe is empty.
    task automatic drain_pipe();
        start    <= 1'b0;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        while (pending_levels.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Register writes are only issued right after drain_pipe.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        if (idx == CFG_DURATION) ramp_duration = val[DUR_W-1:0];
        else if (idx == CFG_KCOUNT) kf_count = val[KC_W-1:0];
        else kf_table[idx - CFG_KF_BASE] = val[KF_W-1:0];
    endtask

    function automatic logic [KF_W-1:0] make_kf(input int prog, input logic [31:0] rgbw);
        return {prog[PROG_W-1:0], rgbw};
    endfunction

    // Directed: the ramp loaded at reset, sampled at its ends and its middle.
    task automatic test_reset_defaults();
        send_sample('0);
        send_sample(DUR_RESET / 2);
        send_sample(DUR_RESET - 1);
        send_sample(DUR_RESET);
        send_sample('1);
    endtask

    // Directed: zero duration completes at once; the widest duration never overflows.
    task automatic test_duration_edges();
        drain_pipe();
        write_reg(CFG_DURATION, '0);
        send_sample(32'd0);
        send_sample(32'd12345);
        drain_pipe();
        write_reg(CFG_DURATION, 42'hFFFF_FFFF);
        send_sample(32'hFFFF_FFFE);
        send_sample(32'h8000_0000);
        send_sample(32'hFFFF_FFFF);
    endtask

    // Directed: a count of zero acts as one and a count of seven as six.
    task automatic test_keyframe_count_limits();
        drain_pipe();
        write_reg(CFG_DURATION, 42'd1000);
        write_reg(CFG_KF_BASE + CFG_IDX_W'(0), make_kf(200, 32'hFF00_80FF));
        write_reg(CFG_KF_BASE + CFG_IDX_W'(1), make_kf(400, 32'h00FF_0000));
        write_reg(CFG_KF_BASE + CFG_IDX_W'(5), make_kf(900, 32'h1020_3040));
        write_reg(CFG_KCOUNT, '0);
        send_sample(32'd100);
        send_sample(32'd700);
        drain_pipe();
        write_reg(CFG_KCOUNT, 42'd7);
        send_sample(32'd300);
        send_sample(32'd950);
    endtask

    // Directed: repeated progress, keyframes out of order, progress above 1000,
    // falling channels, and holding the last color.
    task automatic test_segment_cases();
        drain_pipe();
        write_reg(CFG_KCOUNT, 42'd4);
        write_reg(CFG_KF_BASE + CFG_IDX_W'(0), make_kf(100, 32'hFF00_FF00));
        write_reg(CFG_KF_BASE + CFG_IDX_W'(1), make_kf(100, 32'h00FF_00FF));
        write_reg(CFG_KF_BASE + CFG_IDX_W'(2), make_kf(50, 32'h8080_8080));
        write_reg(CFG_KF_BASE + CFG_IDX_W'(3), make_kf(1023, 32'h0102_FEFF));
        send_sample(32'd0);
        send_sample(32'd100);
        send_sample(32'd101);
        send_sample(32'd500);
        send_sample(32'd999);
        send_sample(32'd1000);
        drain_pipe();
        write_reg(CFG_KCOUNT, 42'd2);
        write_reg(CFG_KF_BASE + CFG_IDX_W'(1), make_kf(600, 32'hFFFF_FFFF));
        send_sample(32'd800);
    endtask

    // Random: each phase loads a fresh ramp, mostly well formed, then samples it.
    task automatic test_random_ramps();
        int          marks [$];
        logic [63:0] hi;
        logic [31:0] dur;
        int          sel;
        for (int phase = 0; phase < 10; phase++) begin
            drain_pipe();
            sel = $urandom_range(0, 9);
            if (phase == 0) dur = '0;
            else if (phase == 1) dur = '1;
            else if (sel < 6) dur = $urandom_range(1, 5000);
            else if (sel < 8) dur = $urandom;
            else dur = $urandom_range(1, 3);
            write_reg(CFG_DURATION, 42'(dur));
            write_reg(CFG_KCOUNT, (phase < 2) ? 42'(phase * 7) : 42'($urandom_range(1, 7)));
            marks.delete();
            for (int k = 0; k < MAX_KF; k++)
                marks.push_back(($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                                            : $urandom_range(0, 1000));
            // Most ramps are ascending; a few keep their random order.
            if ($urandom_range(0, 4) != 0) marks.sort();
            for (int k = 0; k < MAX_KF; k++)
                write_reg(CFG_KF_BASE + CFG_IDX_W'(k), make_kf(marks[k], $urandom));
            for (int n = 0; n < 160; n++) begin
                hi = 64'(dur) + 64'(dur) / 8 + 2;
                if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
                if ($urandom_range(0, 9) == 0) send_sample($urandom);
                else send_sample($urandom_range(0, hi[31:0]));
            end
        end
    endtask

    initial begin
        for (int k = 0; k < MAX_KF; k++) kf_table[k] = '0;
        kf_table[1] = KF1_RESET;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_duration_edges();
        test_keyframe_count_limits();
        test_segment_cases();
        test_random_ramps();
        drain_pipe();
        if (!failed) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
